[rtl/assert_macros.svh]
// Assertion helpers for the attitude filter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/icaf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package icaf_pkg;
    localparam int REG_GAMMA = 0;
    localparam int REG_GAIN  = 1;
    localparam int REG_AOX   = 2;
    localparam int REG_AOY   = 3;
    localparam int REG_AOZ   = 4;
    localparam int REG_GOX   = 5;
    localparam int REG_GOZ   = 6;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_ROLL, ST_PITCH, ST_BLEND, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic sqrt_start;
        logic roll_start;
        logic pitch_start;
        logic blend;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic cordic_done;
        logic blend_done;
    } stat_t;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
        case (i)
            5'd0: atan_q28 = 32'sd210828714;
            5'd1: atan_q28 = 32'sd124459457;
            5'd2: atan_q28 = 32'sd65760959;
            5'd3: atan_q28 = 32'sd33381290;
            5'd4: atan_q28 = 32'sd16755422;
            5'd5: atan_q28 = 32'sd8385879;
            5'd6: atan_q28 = 32'sd4193963;
            5'd7: atan_q28 = 32'sd2097109;
            5'd8: atan_q28 = 32'sd1048571;
            5'd9: atan_q28 = 32'sd524287;
            5'd10: atan_q28 = 32'sd262144;
            5'd11: atan_q28 = 32'sd131072;
            5'd12: atan_q28 = 32'sd65536;
            5'd13: atan_q28 = 32'sd32768;
            5'd14: atan_q28 = 32'sd16384;
            5'd15: atan_q28 = 32'sd8192;
            5'd16: atan_q28 = 32'sd4096;
            5'd17: atan_q28 = 32'sd2048;
            5'd18: atan_q28 = 32'sd1024;
            5'd19: atan_q28 = 32'sd512;
            5'd20: atan_q28 = 32'sd256;
            5'd21: atan_q28 = 32'sd128;
            5'd22: atan_q28 = 32'sd64;
            5'd23: atan_q28 = 32'sd32;
            5'd24: atan_q28 = 32'sd16;
            5'd25: atan_q28 = 32'sd8;
            5'd26: atan_q28 = 32'sd4;
            5'd27: atan_q28 = 32'sd2;
            5'd28: atan_q28 = 32'sd1;
            default: atan_q28 = 32'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

[rtl/icaf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module icaf_ctrl import icaf_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output cmd_t       cmd,
    input  wire stat_t stat
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_start = 1'b1;
                if (stat.sqrt_done)
                    state_next = ST_ROLL;
            end
            ST_ROLL:
            begin
                cmd.roll_start = 1'b1;
                if (stat.cordic_done)
                    state_next = ST_PITCH;
            end
            ST_PITCH:
            begin
                cmd.pitch_start = 1'b1;
                if (stat.cordic_done)
                    state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                cmd.blend = 1'b1;
                if (stat.blend_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                in_ready = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load = 1'b1;
                        state_next = ST_SQRT;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/icaf_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module icaf_datapath import icaf_pkg::*; #(
    parameter int ANGLE_BITS   = 32,
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_idx,
    input  wire logic [15:0]        cfg_data,
    input  wire logic signed [15:0] acc_x,
    input  wire logic signed [15:0] acc_y,
    input  wire logic signed [15:0] acc_z,
    input  wire logic signed [15:0] rate_x,
    input  wire logic signed [15:0] rate_y,
    input  wire logic signed [15:0] rate_z,
    output logic signed [31:0]      roll_angle,
    output logic signed [31:0]      pitch_angle,
    output logic signed [31:0]      yaw_angle
);
    localparam int AB = ANGLE_BITS;
    localparam int MW = (AB > 32) ? AB : 32;
    localparam int W = MW + 20;
    localparam logic signed [W-1:0] AMAX = W'({1'b0, {(AB-1){1'b1}}});
    localparam logic signed [W-1:0] AMIN = -AMAX - W'(1);
    localparam int SW = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    function automatic logic signed [W-1:0] sat(input logic signed [W-1:0] v);
        if (v > AMAX)
            sat = AMAX;
        else if (v < AMIN)
            sat = AMIN;
        else
            sat = v;
    endfunction

    logic [15:0] gamma_reg, gain_reg;
    logic signed [15:0] aox_reg, aoy_reg, aoz_reg, gox_reg, goz_reg;
    logic signed [AB-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [17:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= 16'd26214;
            gain_reg <= 16'd3576;
            aox_reg <= -16'sd492;
            aoy_reg <= -16'sd737;
            aoz_reg <= 16'sd1475;
            gox_reg <= -16'sd46;
            goz_reg <= 16'sd26;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                3'(REG_GAMMA): gamma_reg <= cfg_data;
                3'(REG_GAIN): gain_reg <= cfg_data;
                3'(REG_AOX): aox_reg <= cfg_data;
                3'(REG_AOY): aoy_reg <= cfg_data;
                3'(REG_AOZ): aoz_reg <= cfg_data;
                3'(REG_GOX): gox_reg <= cfg_data;
                3'(REG_GOZ): goz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // remap with offsets; negating a full-range sum needs the 18th bit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= -(18'(acc_y) + 18'(aoy_reg));
            ay_reg <= 18'(acc_x) + 18'(aox_reg);
            az_reg <= -(18'(acc_z) + 18'(aoz_reg));
            gx_reg <= 18'(rate_y);
            gy_reg <= -(18'(rate_x) + 18'(gox_reg));
            gz_reg <= 18'(rate_z) + 18'(goz_reg);
        end
    end

    // bit-serial isqrt of (ay^2+az^2)<<20: 28 steps, one result bit each
    logic [55:0] sq_reg;
    logic [55:0] res_reg;
    logic [4:0] sq_cnt_reg;
    logic sq_busy_reg;
    logic [55:0] sq_bit;
    logic [55:0] sq_trial;
    logic [35:0] ay_sq, az_sq;
    assign sq_bit = 56'd1 << {sq_cnt_reg, 1'b0};
    assign sq_trial = res_reg + sq_bit;
    assign ay_sq = ay_reg * ay_reg;
    assign az_sq = az_reg * az_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_busy_reg <= 1'b0;
        else if (cmd.sqrt_start && !sq_busy_reg && !stat.sqrt_done)
            sq_busy_reg <= 1'b1;
        else if (sq_busy_reg && sq_cnt_reg == 5'd0)
            sq_busy_reg <= 1'b0;
    end

    logic sq_done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_done_reg <= 1'b0;
        else
            sq_done_reg <= sq_busy_reg && sq_cnt_reg == 5'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sq_cnt_reg <= 5'd27;
            res_reg <= '0;
        end
        else if (cmd.sqrt_start && !sq_busy_reg && !sq_done_reg)
            sq_reg <= (56'(ay_sq) + 56'(az_sq)) << 20;
        else if (sq_busy_reg)
        begin
            if (sq_reg >= sq_trial)
            begin
                sq_reg <= sq_reg - sq_trial;
                res_reg <= (res_reg >> 1) + sq_bit;
            end
            else
                res_reg <= res_reg >> 1;
            sq_cnt_reg <= sq_cnt_reg - 5'd1;
        end
    end
    assign stat.sqrt_done = sq_done_reg;

    // shared CORDIC vectoring unit
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic [5:0] ci_reg;
    logic c_busy_reg, c_done_reg;
    logic signed [31:0] acc_roll_reg, acc_pitch_reg;
    logic c_go;
    logic signed [33:0] ix, iy;
    assign c_go = (cmd.roll_start || cmd.pitch_start) && !c_busy_reg && !c_done_reg;
    assign ix = cmd.roll_start ? -(34'(az_reg) <<< 10) : $signed(34'(res_reg));
    assign iy = cmd.roll_start ? -(34'(ay_reg) <<< 10) : (34'(ax_reg) <<< 10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_busy_reg <= 1'b0;
            c_done_reg <= 1'b0;
        end
        else
        begin
            c_done_reg <= c_busy_reg && ci_reg == 6'(SW);
            if (c_go)
                c_busy_reg <= 1'b1;
            else if (c_busy_reg && ci_reg == 6'(SW))
                c_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_go)
        begin
            ci_reg <= '0;
            if (ix == 0 && iy == 0)
            begin
                cx_reg <= '0;
                cy_reg <= '0;
                cz_reg <= '0;
                ci_reg <= 6'(SW);
            end
            else if (ix < 0 && iy >= 0)
            begin
                cx_reg <= iy;
                cy_reg <= -ix;
                cz_reg <= HALF_PI_Q28;
            end
            else if (ix < 0)
            begin
                cx_reg <= -iy;
                cy_reg <= ix;
                cz_reg <= -HALF_PI_Q28;
            end
            else
            begin
                cx_reg <= ix;
                cy_reg <= iy;
                cz_reg <= '0;
            end
        end
        else if (c_busy_reg && ci_reg != 6'(SW))
        begin
            if (cy_reg >= 0)
            begin
                cx_reg <= cx_reg + (cy_reg >>> ci_reg);
                cy_reg <= cy_reg - (cx_reg >>> ci_reg);
                cz_reg <= cz_reg + atan_q28(ci_reg[4:0]);
            end
            else
            begin
                cx_reg <= cx_reg - (cy_reg >>> ci_reg);
                cy_reg <= cy_reg + (cx_reg >>> ci_reg);
                cz_reg <= cz_reg - atan_q28(ci_reg[4:0]);
            end
            ci_reg <= ci_reg + 6'd1;
        end
        else if (c_busy_reg)
        begin
            if (cmd.roll_start)
                acc_roll_reg <= cz_reg;
            else
                acc_pitch_reg <= cz_reg;
        end
    end
    assign stat.cordic_done = c_done_reg;

    // blend sequencer: one shared multiply per cycle
    logic [2:0] b_step_reg;
    logic signed [W-1:0] ga_reg, gb_reg, prod_reg, t_reg;
    logic signed [16:0] g17;
    logic signed [16:0] g_rest;
    logic signed [16:0] gain_s;
    logic signed [35:0] inc_x, inc_y, inc_z;
    logic signed [MW-1:0] m_a;
    logic signed [17:0] m_b;
    logic signed [MW+17:0] m_p;
    logic signed [W-1:0] sum;
    assign g17 = (gamma_reg > 16'd32768) ? 17'sd32768 : $signed({1'b0, gamma_reg});
    assign g_rest = 17'sd32768 - g17;
    assign gain_s = $signed({1'b0, gain_reg});
    assign inc_x = gain_s * gx_reg;
    assign inc_y = gain_s * gy_reg;
    assign inc_z = gain_s * gz_reg;
    assign sum = (prod_reg + t_reg + W'(16384)) >>> 15;

    always_comb
    begin
        m_a = '0;
        m_b = '0;
        case (b_step_reg)
            3'd1:
            begin
                m_a = MW'(ga_reg);
                m_b = 18'(g17);
            end
            3'd2:
            begin
                m_a = MW'(acc_roll_reg);
                m_b = 18'(g_rest);
            end
            3'd3:
            begin
                m_a = MW'(gb_reg);
                m_b = 18'(g17);
            end
            3'd4:
            begin
                m_a = MW'(acc_pitch_reg);
                m_b = 18'(g_rest);
            end
            default: ;
        endcase
    end
    assign m_p = m_a * m_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg <= '0;
            pitch_reg <= '0;
            yaw_reg <= '0;
            b_step_reg <= '0;
        end
        else if (!cmd.blend)
            b_step_reg <= '0;
        else if (b_step_reg != 3'd7)
        begin
            b_step_reg <= b_step_reg + 3'd1;
            case (b_step_reg)
                3'd0:
                begin
                    ga_reg <= sat(W'(roll_reg) + W'(inc_x));
                    gb_reg <= sat(W'(pitch_reg) + W'(inc_y));
                    yaw_reg <= AB'(sat(W'(yaw_reg) + W'(inc_z)));
                end
                3'd1: prod_reg <= W'(m_p);
                3'd2: t_reg <= W'(m_p);
                3'd3:
                begin
                    roll_reg <= AB'(sat(sum));
                    prod_reg <= W'(m_p);
                end
                3'd4: t_reg <= W'(m_p);
                3'd5: pitch_reg <= AB'(sat(sum));
                default: ;
            endcase
        end
    end
    assign stat.blend_done = (b_step_reg == 3'd6);

    assign roll_angle = 32'(roll_reg);
    assign pitch_angle = 32'(pitch_reg);
    assign yaw_angle = 32'(yaw_reg);
endmodule
`default_nettype wire

[rtl/imu_complementary_attitude_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Complementary attitude filter for a six-axis IMU sample stream.
// Input channel: in_valid/in_ready with six raw 16-bit signed axes.
// Output channel: out_valid/out_ready with roll, pitch, yaw in Q28 radians.
// Config port: cfg_we writes cfg_data to register cfg_idx at once
// (0 gamma, 1 gyro gain, 2..4 accel offsets, 5..6 gyro offsets).
// One item at a time: a square root, two CORDIC runs on one shared unit
// and a blending sequence; the next sample is not taken before the result
// is transferred. A zero vector skips the CORDIC iterations.
// The result holds in the output register until transferred; a new sample
// is taken in the same cycle as that transfer, so a stalled receiver
// stalls the input.
// Reset clears the estimates to zero and loads default config values.
module imu_complementary_attitude_filter import icaf_pkg::*; #(
    parameter int ANGLE_BITS   = 32,
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_idx,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] acc_x,
    input  wire logic signed [15:0] acc_y,
    input  wire logic signed [15:0] acc_z,
    input  wire logic signed [15:0] rate_x,
    input  wire logic signed [15:0] rate_y,
    input  wire logic signed [15:0] rate_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      roll_angle,
    output logic signed [31:0]      pitch_angle,
    output logic signed [31:0]      yaw_angle
);
`include "assert_macros.svh"
    cmd_t cmd;
    stat_t stat;

    icaf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
    );

    icaf_datapath #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle)
    );

    `ASSERT_IMPL(a_load_accepts, clk, rst_n, cmd.load, in_valid && in_ready)
    `ASSERT_IMPL(a_no_out_busy, clk, rst_n, out_valid, !cmd.blend && !cmd.sqrt_start)
    `ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid && $stable(yaw_angle))
endmodule
`default_nettype wire
